[design/fsfl_pkg.sv]
// Package for the fixed-slot free-list allocator.
// Holds field widths, request and status codes, and the control state type.
// No dependencies; the two interfaces and the allocator import it.
package fsfl_pkg;

	// Field widths of the request and response transactions.
	localparam int REQ_TYPE_W    = 2;
	localparam int REQ_SIZE_W    = 16;
	localparam int FREE_SLOT_W   = 8;
	localparam int STATUS_W      = 2;
	localparam int SLOT_INDEX_W  = 8;
	localparam int SLOT_OFFSET_W = 20;
	localparam int USED_COUNT_W  = 9;

	// Configuration registers.
	localparam int SLOT_BYTES_W = 13;
	localparam int SLOT_COUNT_W = 9;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_IDX_W    = 1;

	localparam logic [SLOT_BYTES_W-1:0]  SLOT_BYTES_RST = SLOT_BYTES_W'(8);
	localparam logic [SLOT_COUNT_W-1:0]  SLOT_COUNT_RST = SLOT_COUNT_W'(256);
	localparam logic [SLOT_OFFSET_W-1:0] OFFSET_MAX     = 20'hFFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SLOT_BYTES = 1'b0,
		CFG_SLOT_COUNT = 1'b1
	} cfg_idx_t;

	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_INIT  = 2'd0,
		REQ_ALLOC = 2'd1,
		REQ_FREE  = 2'd2,
		REQ_NOP   = 2'd3
	} req_type_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_TOO_LARGE = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_IGNORED   = 2'd3
	} status_t;

	// What an accepted request does to the list once its response is issued.
	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_INIT = 2'd1,
		OP_POP  = 2'd2,
		OP_PUSH = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_INIT = 2'd1,
		S_RESP = 2'd2
	} state_t;

endpackage

[design/fsfl_req_if.sv]
// Request channel of the free-list allocator: valid/ready plus request fields.
// Depends on fsfl_pkg for the field widths.
interface fsfl_req_if import fsfl_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [REQ_TYPE_W-1:0]  req_type;
	logic [REQ_SIZE_W-1:0]  req_size;
	logic [FREE_SLOT_W-1:0] free_slot;
	logic                   free_is_null;

	modport source (output valid, output req_type, output req_size, output free_slot,
		output free_is_null, input ready);
	modport sink (input valid, input req_type, input req_size, input free_slot,
		input free_is_null, output ready);
endinterface

[design/fsfl_rsp_if.sv]
// Response channel of the free-list allocator: valid/ready plus result fields.
// Depends on fsfl_pkg for the field widths.
interface fsfl_rsp_if import fsfl_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic [SLOT_INDEX_W-1:0]  slot_index;
	logic [SLOT_OFFSET_W-1:0] slot_offset;
	logic [USED_COUNT_W-1:0]  used_count;

	modport source (output valid, output status, output slot_index, output slot_offset,
		output used_count, input ready);
	modport sink (input valid, input status, input slot_index, input slot_offset,
		input used_count, output ready);
endinterface

[design/fsfl_link_mem.sv]
// Next-link memory of the free list: one write port, one read port,
// read data registered. No package dependency.
module fsfl_link_mem #(
	parameter int DEPTH  = 256,
	parameter int DATA_W = 9
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/fixed_slot_free_list_allocator.sv]
// Fixed-slot pool allocator built on a LIFO free list held in a link memory.
// Depends on fsfl_pkg, fsfl_req_if, fsfl_rsp_if and fsfl_link_mem.
//
// Usage: each request transaction (init, allocate, free, or no-op) yields exactly
// one response transaction carrying a status, the slot index and byte offset of
// an allocated slot, and the number of slots in use after the request.
// The configuration port writes slot_bytes (index 0) and slot_count (index 1);
// it must be written only while the allocator is idle, which the block itself
// does not enforce, and slot_count takes effect at the next init request.
// Sequence: allocate, free and no-op requests pass through an accept state
// (S_IDLE), which issues the link memory read or write, and a response state
// (S_RESP), in which the read data becomes the new head. An init request walks the
// link memory one entry per cycle in S_INIT, min(slot_count, NUM_SLOTS) entries,
// between the two. One request is in work at a time; the response register lets
// the next request be accepted while an earlier response still waits to be taken.
// Reset leaves the free list empty (head is the null marker), the used count at
// zero and the registers at slot_bytes 8 and slot_count 256; an init request is
// needed before any allocation succeeds. When the receiver stalls, the response
// stays in the output register and a finished request holds in its response
// state, so no request is accepted until the output register drains.
module fixed_slot_free_list_allocator import fsfl_pkg::*; #(
	parameter int NUM_SLOTS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	fsfl_req_if.sink              req,
	fsfl_rsp_if.source            rsp
);

	// A link holds a slot index or the null marker NUM_SLOTS.
	localparam int IDX_W  = $clog2(NUM_SLOTS);
	localparam int LINK_W = IDX_W + 1;
	localparam int PROD_W = IDX_W + SLOT_BYTES_W;
	localparam logic [LINK_W-1:0] NULL_LINK  = LINK_W'(NUM_SLOTS);
	localparam int ACTIVE_RST_I = (int'(SLOT_COUNT_RST) > NUM_SLOTS) ? NUM_SLOTS
		: int'(SLOT_COUNT_RST);
	localparam logic [LINK_W-1:0] ACTIVE_RST = LINK_W'(ACTIVE_RST_I);

	state_t state_q, state_nx;

	logic [SLOT_BYTES_W-1:0] slot_bytes_q;
	logic [SLOT_COUNT_W-1:0] slot_count_q;
	logic [LINK_W-1:0]       head_q;
	logic [LINK_W-1:0]       used_q;
	logic [LINK_W-1:0]       active_q;
	logic [IDX_W-1:0]        cnt_q;

	// Request captured at accept.
	op_t               op_s1;
	status_t           status_s1;
	logic [IDX_W-1:0]  free_idx_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [LINK_W-1:0] init_n_s1;

	// Output register.
	logic                     out_valid_q;
	logic [STATUS_W-1:0]      out_status_q;
	logic [SLOT_INDEX_W-1:0]  out_index_q;
	logic [SLOT_OFFSET_W-1:0] out_offset_q;
	logic [USED_COUNT_W-1:0]  out_used_q;

	logic              req_acc;
	logic              head_null;
	logic [LINK_W-1:0] eff_n;
	op_t               dec_op;
	status_t           dec_status;

	logic              link_we;
	logic [IDX_W-1:0]  link_waddr;
	logic [LINK_W-1:0] link_wdata;
	logic              link_re;
	logic [LINK_W-1:0] link_rdata;

	logic              init_last;
	logic [LINK_W-1:0] cnt_next_link;
	logic              rsp_load;

	logic [LINK_W-1:0]        head_nx;
	logic [LINK_W-1:0]        used_nx;
	logic [SLOT_INDEX_W-1:0]  index_nx;
	logic [SLOT_OFFSET_W-1:0] offset_nx;

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign head_null = (32'(head_q) >= NUM_SLOTS);
	assign eff_n     = (32'(slot_count_q) > NUM_SLOTS) ? LINK_W'(NUM_SLOTS)
		: LINK_W'(slot_count_q);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_bytes_q <= SLOT_BYTES_RST;
			slot_count_q <= SLOT_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SLOT_BYTES: slot_bytes_q <= cfg_wdata[SLOT_BYTES_W-1:0];
				CFG_SLOT_COUNT: slot_count_q <= cfg_wdata[SLOT_COUNT_W-1:0];
			endcase
		end
	end

	// Decode the incoming request into a list operation and a status.
	always_comb begin
		dec_op     = OP_NONE;
		dec_status = STAT_OK;
		unique case (req_type_t'(req.req_type))
			REQ_INIT: begin
				dec_op = OP_INIT;
			end
			REQ_ALLOC: begin
				if (32'(req.req_size) > 32'(slot_bytes_q)) begin
					dec_status = STAT_TOO_LARGE;
				end else if (head_null) begin
					dec_status = STAT_EMPTY;
				end else begin
					dec_op = OP_POP;
				end
			end
			REQ_FREE: begin
				if (req.free_is_null || 32'(req.free_slot) >= NUM_SLOTS) begin
					dec_status = STAT_IGNORED;
				end else begin
					dec_op = OP_PUSH;
				end
			end
			REQ_NOP: begin
				dec_op = OP_NONE;
			end
		endcase
	end

	// The request is held here until its response goes out.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_s1       <= dec_op;
			status_s1   <= dec_status;
			free_idx_s1 <= IDX_W'(req.free_slot);
			prod_s1     <= PROD_W'(head_q[IDX_W-1:0]) * PROD_W'(slot_bytes_q);
			init_n_s1   <= eff_n;
		end
	end

	// Init sweep counter: links entry i to i + 1, the last one to null.
	assign cnt_next_link = LINK_W'(cnt_q) + LINK_W'(1);
	assign init_last     = (cnt_next_link == init_n_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req_acc) begin
			cnt_q <= '0;
		end else if (state_q == S_INIT) begin
			cnt_q <= cnt_q + IDX_W'(1);
		end
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					state_nx = (dec_op == OP_INIT && eff_n != '0) ? S_INIT : S_RESP;
				end
			end
			S_INIT: begin
				if (init_last) begin
					state_nx = S_RESP;
				end
			end
			S_RESP: begin
				if (rsp_load) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// State machine outputs: link memory port control and response load.
	always_comb begin
		link_we    = 1'b0;
		link_waddr = cnt_q;
		link_wdata = cnt_next_link;
		link_re    = 1'b0;
		rsp_load   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_acc && dec_op == OP_PUSH) begin
					link_we    = 1'b1;
					link_waddr = IDX_W'(req.free_slot);
					link_wdata = head_q;
				end
				link_re = req_acc && (dec_op == OP_POP);
			end
			S_INIT: begin
				link_we    = 1'b1;
				link_wdata = init_last ? NULL_LINK : cnt_next_link;
			end
			S_RESP: begin
				rsp_load = !out_valid_q || rsp.ready;
			end
			default: begin
				link_we = 1'b0;
			end
		endcase
	end

	fsfl_link_mem #(
		.DEPTH  (NUM_SLOTS),
		.DATA_W (LINK_W)
	) u_link_mem (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (head_q[IDX_W-1:0]),
		.rdata (link_rdata)
	);

	// Response values and list updates, applied when the response is loaded.
	always_comb begin
		head_nx   = head_q;
		used_nx   = used_q;
		index_nx  = '0;
		offset_nx = '0;
		case (op_s1)
			OP_POP: begin
				head_nx  = link_rdata;
				index_nx = SLOT_INDEX_W'(head_q[IDX_W-1:0]);
				used_nx  = (used_q < active_q) ? used_q + LINK_W'(1) : used_q;
				offset_nx = (32'(prod_s1) > 32'(OFFSET_MAX)) ? OFFSET_MAX
					: SLOT_OFFSET_W'(prod_s1);
			end
			OP_PUSH: begin
				head_nx = LINK_W'(free_idx_s1);
				used_nx = (used_q != '0) ? used_q - LINK_W'(1) : used_q;
			end
			OP_INIT: begin
				head_nx = (init_n_s1 != '0) ? '0 : NULL_LINK;
				used_nx = '0;
			end
			default: begin
				head_nx = head_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= NULL_LINK;
			used_q   <= '0;
			active_q <= ACTIVE_RST;
		end else if (rsp_load) begin
			head_q <= head_nx;
			used_q <= used_nx;
			if (op_s1 == OP_INIT) begin
				active_q <= init_n_s1;
			end
		end
	end

	// Output register: holds a response until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			out_status_q <= status_s1;
			out_index_q  <= index_nx;
			out_offset_q <= offset_nx;
			out_used_q   <= USED_COUNT_W'(used_nx);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.slot_index  = out_index_q;
	assign rsp.slot_offset = out_offset_q;
	assign rsp.used_count  = out_used_q;

`ifndef NO_ASSERTIONS
	// One request at a time: an accept always closes the request port next cycle.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req.ready)
		else $error("request accepted while another is in work");

	// The used count never exceeds the number of slots linked by the last init.
	a_used_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= active_q)
		else $error("used count above active slot count");

	// A pop is only ever committed while the list holds a slot.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load && op_s1 == OP_POP |-> !head_null)
		else $error("pop from an empty free list");

	// The head is a slot index or the null marker, never beyond it.
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |=> 32'(head_q) <= NUM_SLOTS)
		else $error("free list head out of range");
`endif

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for fixed_slot_free_list_allocator.
// Depends on fsfl_pkg, fsfl_req_if, fsfl_rsp_if and the allocator from the design folder.
module tb;
	import fsfl_pkg::*;

	localparam int POOL_DEPTH    = 256;
	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 8;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 160;
	localparam int MAX_REPORTS   = 10;
	// The long receiver hold-off starts once this many responses have been taken.
	localparam int HOLD_AT       = 400;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_LIMIT   = 50000;
	localparam int TAIL_CYCLES   = 16;

	// One request transaction as the testbench builds it.
	typedef struct packed {
		req_type_t             kind;
		logic [REQ_SIZE_W-1:0] size;
		logic [FREE_SLOT_W-1:0] slot;
		logic                  is_null;
	} alloc_req_t;

	// One response transaction, used both for expectations and for printing.
	typedef struct packed {
		status_t                  status;
		logic [SLOT_INDEX_W-1:0]  slot_index;
		logic [SLOT_OFFSET_W-1:0] slot_offset;
		logic [USED_COUNT_W-1:0]  used_count;
	} alloc_rsp_t;

	// A row of the directed table: either a register update or a request. A request
	// row with pinned set carries a hand-written response that replaces the predicted one.
	typedef struct packed {
		bit                      cfg_update;
		logic [SLOT_BYTES_W-1:0] cfg_bytes;
		logic [SLOT_COUNT_W-1:0] cfg_count;
		alloc_req_t              req;
		bit                      pinned;
		alloc_rsp_t              rsp;
	} probe_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	fsfl_req_if req_ch ();
	fsfl_rsp_if rsp_ch ();

	fixed_slot_free_list_allocator #(
		.NUM_SLOTS(POOL_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #HALF_PERIOD clk = ~clk;

	// Shadow copy of the allocator: registers, link memory, head and counters.
	// Register writes land in pool_bytes and pool_count right away; pool_count
	// only shapes the list when the next init request arrives.
	logic [SLOT_BYTES_W-1:0] pool_bytes;
	logic [SLOT_COUNT_W-1:0] pool_count;
	logic [8:0]              pool_link [POOL_DEPTH];
	int unsigned             pool_head;
	int unsigned             pool_used;
	int unsigned             pool_active;

	// Responses still owed by the allocator, oldest first.
	alloc_rsp_t  expected_q[$];
	// Slots that the stimulus believes it holds, so that most frees are legal.
	int unsigned held_slots[$];
	bit          fill_mode;
	bit          send_idle;
	int          mismatches;

	// Applies one request to the shadow pool and returns the response it must give.
	function automatic alloc_rsp_t pool_step(alloc_req_t r);
		alloc_rsp_t       o;
		int unsigned      n;
		int unsigned      i;
		int unsigned      s;
		longint unsigned  off;
		o = '0;
		o.status = STAT_OK;
		case (r.kind)
			REQ_INIT: begin
				// The chain runs 0, 1, ... n-1 so the first allocation gets slot 0.
				n = (pool_count > POOL_DEPTH) ? POOL_DEPTH : pool_count;
				for (i = 0; i < n; i++)
					pool_link[i] = (i + 1 < n) ? 9'(i + 1) : 9'(POOL_DEPTH);
				pool_head = (n > 0) ? 0 : POOL_DEPTH;
				pool_used = 0;
				pool_active = n;
			end
			REQ_ALLOC: begin
				if (r.size > pool_bytes) begin
					o.status = STAT_TOO_LARGE;
				end else if (pool_head >= POOL_DEPTH) begin
					o.status = STAT_EMPTY;
				end else begin
					s = pool_head;
					pool_head = pool_link[s];
					// The count never climbs past the size that the last init chained.
					if (pool_used < pool_active)
						pool_used++;
					off = longint'(s) * longint'(pool_bytes);
					if (off > OFFSET_MAX)
						off = OFFSET_MAX;
					o.slot_index = 8'(s);
					o.slot_offset = 20'(off);
				end
			end
			REQ_FREE: begin
				// Double frees and slots outside the chained range are pushed unchecked.
				if (r.is_null) begin
					o.status = STAT_IGNORED;
				end else begin
					pool_link[r.slot] = 9'(pool_head);
					pool_head = r.slot;
					if (pool_used > 0)
						pool_used--;
				end
			end
			default: ;
		endcase
		o.used_count = 9'(pool_used);
		return o;
	endfunction

	function automatic probe_row_t cfg_row(int bytes, int count);
		probe_row_t row;
		row = '0;
		row.cfg_update = 1'b1;
		row.cfg_bytes = 13'(bytes);
		row.cfg_count = 9'(count);
		return row;
	endfunction

	function automatic probe_row_t req_row(req_type_t k, int size, int slot, bit nul);
		probe_row_t row;
		row = '0;
		row.req.kind = k;
		row.req.size = 16'(size);
		row.req.slot = 8'(slot);
		row.req.is_null = nul;
		return row;
	endfunction

	function automatic probe_row_t pinned_row(req_type_t k, int size, int slot, bit nul,
		status_t st, int idx, int off, int used);
		probe_row_t row;
		row = req_row(k, size, slot, nul);
		row.pinned = 1'b1;
		row.rsp.status = st;
		row.rsp.slot_index = 8'(idx);
		row.rsp.slot_offset = 20'(off);
		row.rsp.used_count = 9'(used);
		return row;
	endfunction

	// Random request mix. Most traffic is legal allocate/free pairs against the slots we
	// hold; fill_mode drifts the balance so the pool both runs dry and drains back out.
	// The rest is noise: inits, no-ops, raw sizes, null frees and frees of any slot.
	function automatic alloc_req_t draw_request();
		alloc_req_t r;
		int         roll;
		int         pick;
		r.kind = REQ_ALLOC;
		r.size = 16'($urandom);
		r.slot = 8'($urandom);
		r.is_null = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 39) == 0)
			fill_mode = !fill_mode;
		roll = $urandom_range(0, 99);
		if (roll < 2) begin
			r.kind = REQ_INIT;
		end else if (roll < 5) begin
			r.kind = REQ_NOP;
		end else if (roll < 9) begin
			// Raw 16-bit size: mostly too large, sometimes not.
			r.kind = REQ_ALLOC;
		end else if (roll < 12) begin
			r.kind = REQ_FREE;
			r.is_null = 1'b1;
		end else if (roll < 15) begin
			r.kind = REQ_FREE;
			r.is_null = 1'b0;
		end else if (held_slots.size() == 0 ||
			$urandom_range(0, 99) < (fill_mode ? 75 : 25)) begin
			r.kind = REQ_ALLOC;
			r.size = 16'($urandom_range(0, pool_bytes));
		end else begin
			pick = $urandom_range(0, held_slots.size() - 1);
			r.kind = REQ_FREE;
			r.is_null = 1'b0;
			r.slot = 8'(held_slots[pick]);
			held_slots.delete(pick);
		end
		return r;
	endfunction

	// Offers one request transaction after a random gap and waits for it to be taken.
	// The expectation is queued at the accepting edge; got returns the predicted response.
	task automatic send_req(alloc_req_t r, bit pinned, alloc_rsp_t pinned_rsp,
		output alloc_rsp_t got);
		int gap;
		if ($urandom_range(0, 31) == 0)
			send_idle = !send_idle;
		gap = send_idle ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= r.kind;
		req_ch.req_size <= r.size;
		req_ch.free_slot <= r.slot;
		req_ch.free_is_null <= r.is_null;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		got = pool_step(r);
		expected_q.push_back(pinned ? pinned_rsp : got);
	endtask

	// Registers only change while the allocator is idle: stop offering, let every owed
	// response come back, wait out the settle period, then write both registers.
	task automatic configure_pool(logic [SLOT_BYTES_W-1:0] bytes,
		logic [SLOT_COUNT_W-1:0] count);
		req_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SLOT_BYTES;
		cfg_wdata <= CFG_DATA_W'(bytes);
		@(posedge clk);
		cfg_index <= CFG_SLOT_COUNT;
		cfg_wdata <= CFG_DATA_W'(count);
		@(posedge clk);
		cfg_we <= 1'b0;
		pool_bytes = bytes;
		pool_count = count;
	endtask

	// Stimulus: reset, the directed table, then random phases, each under its own
	// register setting and opened by an init. The run ends once every owed response
	// has been checked.
	initial begin
		probe_row_t  probe_table[$];
		alloc_req_t  r;
		alloc_rsp_t  got;
		int          spin;
		logic [SLOT_BYTES_W-1:0] bytes;
		logic [SLOT_COUNT_W-1:0] count;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_SLOT_BYTES;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_NOP;
		req_ch.req_size <= '0;
		req_ch.free_slot <= '0;
		req_ch.free_is_null <= 1'b0;

		pool_bytes = SLOT_BYTES_RST;
		pool_count = SLOT_COUNT_RST;
		foreach (pool_link[i])
			pool_link[i] = '0;
		pool_head = POOL_DEPTH;
		pool_used = 0;
		pool_active = POOL_DEPTH;
		fill_mode = 1'b1;
		send_idle = 1'b1;
		mismatches = 0;

		// Out of reset the list is empty, so nothing can be allocated yet.
		probe_table.push_back(pinned_row(REQ_ALLOC, 0, 0, 0, STAT_EMPTY, 0, 0, 0));
		// The size check comes before the empty check.
		probe_table.push_back(pinned_row(REQ_ALLOC, 'hFFFF, 'hFF, 1,
			STAT_TOO_LARGE, 0, 0, 0));
		probe_table.push_back(pinned_row(REQ_FREE, 0, 'hFF, 1, STAT_IGNORED, 0, 0, 0));
		probe_table.push_back(pinned_row(REQ_NOP, 'hFFFF, 'hFF, 1, STAT_OK, 0, 0, 0));
		probe_table.push_back(pinned_row(REQ_INIT, 0, 0, 0, STAT_OK, 0, 0, 0));
		// Allocation order after init is ascending from slot 0.
		probe_table.push_back(pinned_row(REQ_ALLOC, 8, 0, 0, STAT_OK, 0, 0, 1));
		probe_table.push_back(pinned_row(REQ_ALLOC, 9, 0, 0, STAT_TOO_LARGE, 0, 0, 1));
		probe_table.push_back(pinned_row(REQ_ALLOC, 1, 0, 0, STAT_OK, 1, 8, 2));
		// A double free goes through, and the used count stops at zero.
		probe_table.push_back(pinned_row(REQ_FREE, 0, 0, 0, STAT_OK, 0, 0, 1));
		probe_table.push_back(pinned_row(REQ_FREE, 0, 0, 0, STAT_OK, 0, 0, 0));
		probe_table.push_back(pinned_row(REQ_FREE, 0, 1, 0, STAT_OK, 0, 0, 0));
		probe_table.push_back(req_row(REQ_ALLOC, 8, 0, 0));
		// Largest slot size with a slot count beyond the built depth.
		probe_table.push_back(cfg_row(8191, 300));
		probe_table.push_back(pinned_row(REQ_INIT, 0, 0, 0, STAT_OK, 0, 0, 0));
		// Freeing the top slot puts it on the head; its offset no longer fits 20 bits.
		probe_table.push_back(pinned_row(REQ_FREE, 0, 255, 0, STAT_OK, 0, 0, 0));
		probe_table.push_back(pinned_row(REQ_ALLOC, 8191, 0, 0,
			STAT_OK, 255, 'hFFFFF, 1));
		probe_table.push_back(pinned_row(REQ_ALLOC, 8192, 0, 0, STAT_TOO_LARGE, 0, 0, 1));
		probe_table.push_back(req_row(REQ_ALLOC, 100, 0, 0));
		// A zero slot count leaves the list empty; zero-byte slots are taken as given.
		probe_table.push_back(cfg_row(0, 0));
		probe_table.push_back(pinned_row(REQ_INIT, 0, 0, 0, STAT_OK, 0, 0, 0));
		probe_table.push_back(pinned_row(REQ_ALLOC, 0, 0, 0, STAT_EMPTY, 0, 0, 0));
		probe_table.push_back(req_row(REQ_FREE, 0, 5, 0));
		probe_table.push_back(pinned_row(REQ_ALLOC, 1, 0, 0, STAT_TOO_LARGE, 0, 0, 0));
		// The used count is capped by the zero count that init chained.
		probe_table.push_back(pinned_row(REQ_ALLOC, 0, 0, 0, STAT_OK, 5, 0, 0));
		// A one-slot pool runs dry after a single allocation.
		probe_table.push_back(cfg_row(3, 1));
		probe_table.push_back(pinned_row(REQ_INIT, 0, 0, 0, STAT_OK, 0, 0, 0));
		probe_table.push_back(pinned_row(REQ_ALLOC, 3, 0, 0, STAT_OK, 0, 0, 1));
		probe_table.push_back(pinned_row(REQ_ALLOC, 0, 0, 0, STAT_EMPTY, 0, 0, 1));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probe_table[i]) begin
			if (probe_table[i].cfg_update)
				configure_pool(probe_table[i].cfg_bytes, probe_table[i].cfg_count);
			else
				send_req(probe_table[i].req, probe_table[i].pinned, probe_table[i].rsp, got);
		end

		for (int p = 0; p < PHASES; p++) begin
			// The first phases pin fixed register settings, extremes among them; later ones are random, with
			// mostly small pools so that the list often runs empty.
			case (p)
				0: begin bytes = 8191; count = 256; end
				1: begin bytes = 1;    count = 2;   end
				2: begin bytes = 4096; count = 511; end
				3: begin bytes = 8;    count = 16;  end
				default: begin
					bytes = 13'($urandom_range(0, 8191));
					count = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
						: 9'($urandom_range(1, 40));
				end
			endcase
			configure_pool(bytes, count);
			held_slots.delete();
			r = '0;
			r.kind = REQ_INIT;
			send_req(r, 1'b0, '0, got);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				r = draw_request();
				send_req(r, 1'b0, '0, got);
				if (r.kind == REQ_INIT)
					held_slots.delete();
				else if (r.kind == REQ_ALLOC && got.status == STAT_OK)
					held_slots.push_back(got.slot_index);
			end
		end

		req_ch.valid <= 1'b0;
		spin = 0;
		while (expected_q.size() != 0 && spin < DRAIN_LIMIT) begin
			@(posedge clk);
			spin++;
		end
		// An idle tail after the drain catches any stray response transaction.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// Response side: takes response transactions with random stalls, holds off once for
	// a long stretch so the allocator backs up into its request port, and checks each
	// response against the oldest expectation.
	initial begin
		int         stall;
		int         seen;
		bit         recv_idle;
		alloc_rsp_t want;
		rsp_ch.ready <= 1'b0;
		seen = 0;
		recv_idle = 1'b1;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				recv_idle = !recv_idle;
			stall = recv_idle ? $urandom_range(0, 8) : 0;
			if (seen == HOLD_AT)
				stall = HOLD_CYCLES;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
			seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("response %0d arrived with none outstanding: status %0d index %0d offset 0x%0h used %0d",
						seen, rsp_ch.status, rsp_ch.slot_index, rsp_ch.slot_offset,
						rsp_ch.used_count);
			end else begin
				want = expected_q.pop_front();
				if (rsp_ch.status !== want.status || rsp_ch.slot_index !== want.slot_index ||
					rsp_ch.slot_offset !== want.slot_offset ||
					rsp_ch.used_count !== want.used_count) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("response %0d: expected status %0d index %0d offset 0x%0h used %0d, got status %0d index %0d offset 0x%0h used %0d",
							seen, want.status, want.slot_index, want.slot_offset,
							want.used_count, rsp_ch.status, rsp_ch.slot_index,
							rsp_ch.slot_offset, rsp_ch.used_count);
				end
			end
		end
	end

	// Watchdog: far beyond the slowest legal run, including every init walking the pool.
	initial begin
		#5_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule

[files.f]
design/fsfl_pkg.sv
design/fsfl_req_if.sv
design/fsfl_rsp_if.sv
design/fsfl_link_mem.sv
design/fixed_slot_free_list_allocator.sv
verif/tb.sv
